// ----- rtl/huffman_bit_decoder_unit_assert.svh -----
// Assertion macros for the Huffman bit decoder
`ifndef HUFFMAN_BIT_DECODER_UNIT_ASSERT_SVH
`define HUFFMAN_BIT_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define HBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HBD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define HBD_ASSERT(lbl, prop, msg)
`define HBD_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/hbd_pkg.sv -----
package hbd_pkg;

	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_MAX_CODE_LEN  = 32;

	localparam int SYM_W   = 8;
	localparam int ACC_W   = 32;
	localparam int LEN_W   = 6;
	localparam int CNT_W   = 20;
	localparam int IDX_W   = 8;
	localparam int CFG_W   = 9;
	localparam int PADDR_W = 3;

	localparam int NUM_CELLS = 8;
	localparam int CELL_W    = 3;
	localparam int TOK_ROW_W = IDX_W - CELL_W;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_BIT  = 2'd1;
	localparam logic [1:0] FUNC_END  = 2'd2;

	localparam logic [1:0] ST_DECODED  = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_END_DATA = 2'd2;
	localparam logic [1:0] ST_END_NONE = 2'd3;

	localparam logic [PADDR_W-1:0] REG_ENTRIES_IN_USE = 3'd0;

	typedef struct packed {
		logic [1:0]       func;
		logic [IDX_W-1:0] entry_index;
		logic [SYM_W-1:0] entry_symbol;
		logic [ACC_W-1:0] entry_code;
		logic [LEN_W-1:0] entry_length;
		logic             data_bit;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [SYM_W-1:0] symbol;
		logic [CNT_W-1:0] decoded_count;
	} result_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic [ACC_W-1:0] code;
		logic [LEN_W-1:0] length;
	} entry_t;

	// search token passed along the cell row
	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic [TOK_ROW_W-1:0] row;
		logic                 done;
		logic                 hit;
		logic [SYM_W-1:0]     sym;
	} token_t;

endpackage

// ----- rtl/hbd_cell.sv -----
module hbd_cell #(
	parameter int TABLE_ENTRIES = hbd_pkg::DEF_TABLE_ENTRIES,
	parameter int CELL_IDX      = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [hbd_pkg::IDX_W-1:0]   wr_idx,
	input  hbd_pkg::entry_t             wr_entry,
	input  logic [hbd_pkg::ACC_W-1:0]   acc,
	input  logic [hbd_pkg::LEN_W-1:0]   acc_len,
	input  logic [hbd_pkg::CFG_W-1:0]   n_eff,
	input  hbd_pkg::token_t             tok_in,
	output hbd_pkg::token_t             tok_out
);

	localparam int ROWS  = (TABLE_ENTRIES + hbd_pkg::NUM_CELLS - 1) / hbd_pkg::NUM_CELLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [hbd_pkg::CELL_W-1:0] MY_IDX = hbd_pkg::CELL_W'(CELL_IDX);

	hbd_pkg::entry_t mem [ROWS];
	hbd_pkg::entry_t rd_q;
	hbd_pkg::token_t tok_q;

	logic                       my_wr;
	logic [ROW_W-1:0]           wr_row;
	logic [hbd_pkg::IDX_W-1:0]  idx;
	logic                       in_range;
	logic [hbd_pkg::ACC_W-1:0]  lm;
	logic                       eq;

	assign my_wr  = wr_en && (wr_idx[hbd_pkg::CELL_W-1:0] == MY_IDX);
	assign wr_row = wr_idx[hbd_pkg::CELL_W +: ROW_W];

	always_ff @(posedge clk) begin
		if (my_wr) begin
			mem[wr_row] <= wr_entry;
		end
		rd_q <= mem[tok_in.row[ROW_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	assign idx      = {tok_q.row, MY_IDX};
	assign in_range = {1'b0, idx} < n_eff;
	assign lm       = (rd_q.length >= hbd_pkg::LEN_W'(hbd_pkg::ACC_W)) ? '1
			: ~({hbd_pkg::ACC_W{1'b1}} << rd_q.length);
	assign eq       = (rd_q.length != '0) && (rd_q.length == acc_len)
			&& (((rd_q.code ^ acc) & lm) == '0);

	always_comb begin
		tok_out = tok_q;
		if (tok_q.valid && !tok_q.done && in_range && eq) begin
			tok_out.done = 1'b1;
			tok_out.hit  = (rd_q.symbol != '0);
			tok_out.sym  = rd_q.symbol;
		end
	end

endmodule

// ----- rtl/huffman_bit_decoder_unit.sv -----
// Huffman bit decoder: bit-serial decode against a loaded code table.
// Items enter on cmd when start is high and busy is low. func selects:
//   load  - writes one table entry; no result.
//   bit   - shifts data_bit into the accumulator and searches entries
//           0 .. entries_in_use-1 for the first of equal length and code.
//   end   - reports the decoded count and clears the stream state.
// The table sits in a row of 8 cells, entry i in cell i mod 8. A search
// token walks the row, one cell per cycle, one table row issued per cycle,
// and a bit item keeps busy high until the last row issued (rows for the
// entries in use, clamped to the table size, at least one) leaves the row;
// the result, if any, shows in the first cycle with busy low. Load and end
// items do not raise busy; the end result appears on the following cycle.
// result is valid for exactly one cycle while strobe is high; the receiver
// cannot stall, so a result is never held.
// entries_in_use is written over the APB port at byte address 0.
// Reset clears accumulator, count, register and control state; table
// contents are undefined until loaded.
`include "huffman_bit_decoder_unit_assert.svh"

module huffman_bit_decoder_unit #(
	parameter int TABLE_ENTRIES = hbd_pkg::DEF_TABLE_ENTRIES,
	parameter int MAX_CODE_LEN  = hbd_pkg::DEF_MAX_CODE_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  hbd_pkg::cmd_t                 cmd,
	output logic                          strobe,
	output hbd_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hbd_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int LIMIT = (MAX_CODE_LEN > 63) ? 63 : MAX_CODE_LEN;
	localparam int NC    = hbd_pkg::NUM_CELLS;

	logic [hbd_pkg::CFG_W-1:0]     n_reg_q;
	logic [hbd_pkg::CFG_W-1:0]     n_eff;
	logic [hbd_pkg::CFG_W-1:0]     n_m1;
	logic [hbd_pkg::ACC_W-1:0]     acc_q;
	logic [hbd_pkg::LEN_W-1:0]     len_q;
	logic [hbd_pkg::CNT_W-1:0]     cnt_q;
	logic [hbd_pkg::CNT_W-1:0]     cnt_inc;
	logic                          busy_q;
	logic                          issue_q;
	logic [hbd_pkg::TOK_ROW_W-1:0] row_q;
	logic [hbd_pkg::TOK_ROW_W-1:0] last_row_q;
	logic [hbd_pkg::TOK_ROW_W-1:0] last_row;
	logic                          found_q;
	logic                          hit_q;
	logic [hbd_pkg::SYM_W-1:0]     sym_q;
	logic                          strobe_q;
	hbd_pkg::result_t              res_q;

	logic                          accept;
	logic                          wr_en;
	logic                          fin;
	logic                          hit_any;
	logic [hbd_pkg::SYM_W-1:0]     sym_any;
	hbd_pkg::entry_t               wr_entry;
	hbd_pkg::token_t               tok [NC+1];
	hbd_pkg::token_t               ex;

	assign accept = start && !busy_q;
	assign wr_en  = accept && (cmd.func == hbd_pkg::FUNC_LOAD)
			&& ({1'b0, cmd.entry_index} < hbd_pkg::CFG_W'(TABLE_ENTRIES));

	assign wr_entry.symbol = cmd.entry_symbol;
	assign wr_entry.code   = cmd.entry_code;
	assign wr_entry.length = cmd.entry_length;

	assign n_eff    = (n_reg_q > hbd_pkg::CFG_W'(TABLE_ENTRIES))
			? hbd_pkg::CFG_W'(TABLE_ENTRIES) : n_reg_q;
	assign n_m1     = n_eff - 1'b1;
	assign last_row = (n_eff == '0) ? '0
			: n_m1[hbd_pkg::CELL_W +: hbd_pkg::TOK_ROW_W];

	assign tok[0].valid = issue_q;
	assign tok[0].last  = (row_q == last_row_q);
	assign tok[0].row   = row_q;
	assign tok[0].done  = 1'b0;
	assign tok[0].hit   = 1'b0;
	assign tok[0].sym   = '0;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		hbd_cell #(
			.TABLE_ENTRIES(TABLE_ENTRIES),
			.CELL_IDX     (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en),
			.wr_idx  (cmd.entry_index),
			.wr_entry(wr_entry),
			.acc     (acc_q),
			.acc_len (len_q),
			.n_eff   (n_eff),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	assign ex      = tok[NC];
	assign fin     = ex.valid && ex.last;
	assign hit_any = found_q ? hit_q : (ex.valid && ex.done && ex.hit);
	assign sym_any = found_q ? sym_q : ex.sym;
	assign cnt_inc = (cnt_q == hbd_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_reg_q    <= '0;
			acc_q      <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			busy_q     <= 1'b0;
			issue_q    <= 1'b0;
			row_q      <= '0;
			last_row_q <= '0;
			found_q    <= 1'b0;
			hit_q      <= 1'b0;
			sym_q      <= '0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (psel && penable && pwrite && (paddr == hbd_pkg::REG_ENTRIES_IN_USE)) begin
				n_reg_q <= pwdata[hbd_pkg::CFG_W-1:0];
			end
			if (accept && (cmd.func == hbd_pkg::FUNC_BIT)) begin
				acc_q      <= {acc_q[hbd_pkg::ACC_W-2:0], cmd.data_bit};
				len_q      <= len_q + 1'b1;
				busy_q     <= 1'b1;
				issue_q    <= 1'b1;
				row_q      <= '0;
				last_row_q <= last_row;
				found_q    <= 1'b0;
			end
			if (accept && (cmd.func == hbd_pkg::FUNC_END)) begin
				strobe_q <= 1'b1;
				cnt_q    <= '0;
				acc_q    <= '0;
				len_q    <= '0;
			end
			if (issue_q) begin
				if (row_q == last_row_q) begin
					issue_q <= 1'b0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			if (ex.valid && ex.done && !found_q) begin
				found_q <= 1'b1;
				hit_q   <= ex.hit;
				sym_q   <= ex.sym;
			end
			if (fin) begin
				busy_q <= 1'b0;
				if (hit_any) begin
					strobe_q <= 1'b1;
					cnt_q    <= cnt_inc;
					acc_q    <= '0;
					len_q    <= '0;
				end else if (len_q >= hbd_pkg::LEN_W'(LIMIT)) begin
					strobe_q <= 1'b1;
					acc_q    <= '0;
					len_q    <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd.func == hbd_pkg::FUNC_END)) begin
			res_q.status        <= (cnt_q != '0) ? hbd_pkg::ST_END_DATA : hbd_pkg::ST_END_NONE;
			res_q.symbol        <= '0;
			res_q.decoded_count <= cnt_q;
		end else if (fin) begin
			if (hit_any) begin
				res_q.status        <= hbd_pkg::ST_DECODED;
				res_q.symbol        <= sym_any;
				res_q.decoded_count <= cnt_inc;
			end else begin
				res_q.status        <= hbd_pkg::ST_OVERFLOW;
				res_q.symbol        <= '0;
				res_q.decoded_count <= cnt_q;
			end
		end
	end

	assign busy   = busy_q;
	assign strobe = strobe_q;
	assign result = res_q;
	assign pready = 1'b1;
	assign prdata = (paddr == hbd_pkg::REG_ENTRIES_IN_USE) ? 32'(n_reg_q) : '0;

	`HBD_ASSERT(a_sym_nonzero, strobe && (result.status == hbd_pkg::ST_DECODED) |-> result.symbol != '0, "decoded symbol zero")
	`HBD_NEVER(a_strobe_busy, strobe && busy_q, "result while search running")
	`HBD_ASSERT(a_issue_busy, issue_q |-> busy_q, "row issued while idle")
	`HBD_ASSERT(a_len_bound, !busy_q |-> len_q < hbd_pkg::LEN_W'(LIMIT), "code length past limit")

endmodule

// ----- dv/tb_huffman_bit_decoder_unit.sv -----
module tb_huffman_bit_decoder_unit;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int LEN_LIMIT = (hbd_pkg::DEF_MAX_CODE_LEN > 63) ? 63 : hbd_pkg::DEF_MAX_CODE_LEN;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	hbd_pkg::cmd_t cmd = '0;
	logic strobe;
	hbd_pkg::result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [hbd_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// decoder state as the block should hold it
	logic [hbd_pkg::SYM_W-1:0] code_sym [hbd_pkg::DEF_TABLE_ENTRIES];
	logic [hbd_pkg::ACC_W-1:0] code_bits [hbd_pkg::DEF_TABLE_ENTRIES];
	logic [hbd_pkg::LEN_W-1:0] code_len [hbd_pkg::DEF_TABLE_ENTRIES];
	logic [hbd_pkg::ACC_W-1:0] shift_reg = '0;
	logic [hbd_pkg::LEN_W-1:0] shift_len = '0;
	logic [hbd_pkg::CNT_W-1:0] run_count = '0;
	logic [hbd_pkg::CFG_W-1:0] entries_in_use = '0;

	// table contents as queued, used to build well-formed bit streams
	logic [hbd_pkg::ACC_W-1:0] plan_code [hbd_pkg::DEF_TABLE_ENTRIES];
	logic [hbd_pkg::LEN_W-1:0] plan_len [hbd_pkg::DEF_TABLE_ENTRIES];

	hbd_pkg::cmd_t pending_cmds[$];
	hbd_pkg::result_t expected_results[$];
	hbd_pkg::result_t want_res;

	int gap_pct = 0;
	int errors = 0;
	int items_accepted = 0;
	int symbols_seen = 0;
	int overflows_seen = 0;
	int ends_seen = 0;
	int cfg_writes = 0;
	int cycle_count = 0;

	huffman_bit_decoder_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.strobe  (strobe),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial forever #5 clk = ~clk;

	task automatic predict_decode(input hbd_pkg::cmd_t c);
		int limit;
		int i;
		bit found;
		logic [hbd_pkg::SYM_W-1:0] sym;
		logic [hbd_pkg::ACC_W-1:0] mask;
		hbd_pkg::result_t r;
		r = '0;
		found = 1'b0;
		sym = '0;
		case (c.func)
			hbd_pkg::FUNC_LOAD: begin
				code_sym[c.entry_index] = c.entry_symbol;
				code_bits[c.entry_index] = c.entry_code;
				code_len[c.entry_index] = c.entry_length;
			end
			hbd_pkg::FUNC_BIT: begin
				shift_reg = {shift_reg[hbd_pkg::ACC_W-2:0], c.data_bit};
				shift_len = shift_len + 1'b1;
				limit = (entries_in_use > hbd_pkg::DEF_TABLE_ENTRIES) ?
					hbd_pkg::DEF_TABLE_ENTRIES : entries_in_use;
				mask = (shift_len >= 32) ? 32'hFFFF_FFFF : (32'h1 << shift_len) - 32'h1;
				for (i = 0; i < limit && !found; i++) begin
					if (code_len[hbd_pkg::IDX_W'(i)] != 0 &&
					    code_len[hbd_pkg::IDX_W'(i)] == shift_len &&
					    (code_bits[hbd_pkg::IDX_W'(i)] & mask) == (shift_reg & mask)) begin
						found = 1'b1;
						sym = code_sym[hbd_pkg::IDX_W'(i)];
					end
				end
				// a zero symbol stops the search without a match
				if (found && sym != 0) begin
					if (run_count != hbd_pkg::CNT_MAX)
						run_count = run_count + 1'b1;
					shift_reg = '0;
					shift_len = '0;
					r.status = hbd_pkg::ST_DECODED;
					r.symbol = sym;
					r.decoded_count = run_count;
					expected_results.push_back(r);
				end else if (shift_len >= LEN_LIMIT) begin
					shift_reg = '0;
					shift_len = '0;
					r.status = hbd_pkg::ST_OVERFLOW;
					r.decoded_count = run_count;
					expected_results.push_back(r);
				end
			end
			hbd_pkg::FUNC_END: begin
				r.status = (run_count != 0) ? hbd_pkg::ST_END_DATA : hbd_pkg::ST_END_NONE;
				r.decoded_count = run_count;
				expected_results.push_back(r);
				run_count = '0;
				shift_reg = '0;
				shift_len = '0;
			end
			default: ;
		endcase
	endtask

	task automatic note_failure(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_decode(cmd);
				items_accepted++;
			end
			if (!start || !busy) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					start <= 1'b1;
					cmd <= pending_cmds.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				note_failure($sformatf("unexpected result: status %0d symbol %02h count %0d",
					result.status, result.symbol, result.decoded_count));
			end else begin
				want_res = expected_results.pop_front();
				case (want_res.status)
					hbd_pkg::ST_DECODED: symbols_seen++;
					hbd_pkg::ST_OVERFLOW: overflows_seen++;
					default: ends_seen++;
				endcase
				if (result.status !== want_res.status || result.symbol !== want_res.symbol ||
				    result.decoded_count !== want_res.decoded_count)
					note_failure($sformatf(
						"mismatch: exp status %0d symbol %02h count %0d, got %0d %02h %0d",
						want_res.status, want_res.symbol, want_res.decoded_count,
						result.status, result.symbol, result.decoded_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("huffman_bit_decoder_unit test failed");
			$finish;
		end
	end

	function automatic hbd_pkg::cmd_t rand_cmd();
		hbd_pkg::cmd_t c;
		c.func = 2'($urandom_range(0, 3));
		c.entry_index = 8'($urandom);
		c.entry_symbol = 8'($urandom);
		c.entry_code = $urandom;
		c.entry_length = 6'($urandom);
		c.data_bit = 1'($urandom);
		return c;
	endfunction

	task automatic queue_load(input int idx, input logic [7:0] sym, input logic [31:0] code,
			input logic [5:0] len);
		hbd_pkg::cmd_t c;
		c = rand_cmd();
		c.func = hbd_pkg::FUNC_LOAD;
		c.entry_index = 8'(idx);
		c.entry_symbol = sym;
		c.entry_code = code;
		c.entry_length = len;
		plan_code[hbd_pkg::IDX_W'(idx)] = code;
		plan_len[hbd_pkg::IDX_W'(idx)] = len;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_func(input logic [1:0] f, input logic b);
		hbd_pkg::cmd_t c;
		c = rand_cmd();
		c.func = f;
		c.data_bit = b;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_noise(inout int bits_done);
		hbd_pkg::cmd_t c;
		c = rand_cmd();
		if (c.func == hbd_pkg::FUNC_LOAD) begin
			plan_code[c.entry_index] = c.entry_code;
			plan_len[c.entry_index] = c.entry_length;
		end
		if (c.func == hbd_pkg::FUNC_BIT)
			bits_done++;
		pending_cmds.push_back(c);
	endtask

	// bits of one table code, first bit most significant
	task automatic queue_code(input int j, inout int bits_done);
		int b;
		if (plan_len[hbd_pkg::IDX_W'(j)] == 0 || plan_len[hbd_pkg::IDX_W'(j)] > 32) begin
			queue_func(hbd_pkg::FUNC_BIT, 1'($urandom));
			bits_done++;
		end else begin
			for (b = plan_len[hbd_pkg::IDX_W'(j)] - 1; b >= 0; b--) begin
				queue_func(hbd_pkg::FUNC_BIT, plan_code[hbd_pkg::IDX_W'(j)][5'(b)]);
				bits_done++;
			end
		end
	endtask

	// canonical prefix-free codes in slots 0..n-2, all-ones 32-bit code in the last slot
	task automatic queue_code_table(input int n);
		longint unsigned c;
		int len;
		int i;
		logic [7:0] sym;
		c = 0;
		len = $urandom_range(1, 3);
		for (i = 0; i < n - 1; i++) begin
			if (i > 0) begin
				c++;
				if ($urandom_range(0, 3) == 0 && len < 31) begin
					c = c << 1;
					len++;
				end
				while (c + 1 >= (64'd1 << len) && len < 31) begin
					c = c << 1;
					len++;
				end
			end
			sym = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
			queue_load(i, sym, 32'(c), 6'(len));
		end
		queue_load(n - 1, 8'hFF, 32'hFFFF_FFFF, 6'd32);
	endtask

	task automatic queue_stream(input int n, input int bit_goal);
		int bits_done;
		int r;
		bits_done = 0;
		while (bits_done < bit_goal) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				queue_func(hbd_pkg::FUNC_END, 1'($urandom));
			else if (r < 10)
				queue_noise(bits_done);
			else
				queue_code($urandom_range(0, n - 1), bits_done);
		end
		queue_func(hbd_pkg::FUNC_END, 1'($urandom));
	endtask

	task automatic wait_idle(input bit for_results);
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || start || busy ||
		       (for_results && expected_results.size() != 0));
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_entries(input int val);
		wait_idle(1'b1);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= hbd_pkg::REG_ENTRIES_IN_USE;
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		entries_in_use = hbd_pkg::CFG_W'(val);
		cfg_writes++;
		@(negedge clk);
		if (prdata !== 32'(entries_in_use))
			note_failure($sformatf("register read back: exp %0d got %0d",
				entries_in_use, prdata));
	endtask

	initial begin
		int i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: end with nothing decoded, unused code, special table entries
		queue_func(hbd_pkg::FUNC_END, 1'b0);
		queue_func(FUNC_UNUSED, 1'b1);
		queue_load(0, 8'h41, 32'h0, 6'd1);
		queue_load(1, 8'h00, 32'h2, 6'd2);
		queue_load(2, 8'hFF, 32'hFFFF_FFFF, 6'd32);
		queue_load(3, 8'h33, 32'h0, 6'd0);
		queue_load(4, 8'h55, 32'hF0F0_F0F0, 6'd63);
		queue_load(5, 8'h12, 32'h6, 6'd3);
		queue_load(6, 8'h99, 32'h0, 6'd1);
		set_entries(7);
		queue_func(hbd_pkg::FUNC_BIT, 1'b0);
		queue_func(hbd_pkg::FUNC_BIT, 1'b1);
		queue_func(hbd_pkg::FUNC_BIT, 1'b0);
		queue_func(hbd_pkg::FUNC_BIT, 1'b1);
		queue_func(hbd_pkg::FUNC_END, 1'b0);
		queue_func(hbd_pkg::FUNC_END, 1'b1);
		queue_func(hbd_pkg::FUNC_BIT, 1'b1);
		queue_func(hbd_pkg::FUNC_BIT, 1'b1);
		queue_func(hbd_pkg::FUNC_BIT, 1'b0);
		queue_func(hbd_pkg::FUNC_BIT, 1'b1);
		queue_func(hbd_pkg::FUNC_BIT, 1'b1);
		queue_func(hbd_pkg::FUNC_END, 1'b0);

		// empty search: every 32 bits overflow
		set_entries(0);
		for (i = 0; i < 70; i++)
			queue_func(hbd_pkg::FUNC_BIT, 1'($urandom));
		queue_func(hbd_pkg::FUNC_END, 1'b0);

		gap_pct = 54;
		wait_idle(1'b1);
		queue_code_table(8);
		set_entries(8);
		queue_stream(8, 150);

		gap_pct = 26;
		wait_idle(1'b1);
		queue_code_table(hbd_pkg::DEF_TABLE_ENTRIES);
		set_entries(hbd_pkg::DEF_TABLE_ENTRIES);
		queue_stream(hbd_pkg::DEF_TABLE_ENTRIES, 150);

		gap_pct = 0;
		set_entries(511);
		queue_stream(hbd_pkg::DEF_TABLE_ENTRIES, 100);

		gap_pct = 54;
		wait_idle(1'b1);
		queue_code_table(9);
		set_entries(9);
		queue_stream(9, 150);

		gap_pct = 26;
		set_entries(1);
		queue_stream(1, 60);

		wait_idle(1'b0);
		if (expected_results.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_results.size()));
		$display("%0d items accepted over %0d entries_in_use settings (0 to 511)",
			items_accepted, cfg_writes);
		$display("checked %0d decoded symbols, %0d overflows, %0d end reports; %0d errors",
			symbols_seen, overflows_seen, ends_seen, errors);
		if (errors == 0)
			$display("huffman_bit_decoder_unit test passed");
		else
			$display("huffman_bit_decoder_unit test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hbd_pkg.sv
rtl/hbd_cell.sv
rtl/huffman_bit_decoder_unit.sv
dv/tb_huffman_bit_decoder_unit.sv
